// ===== hw/rtl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// PIR motion qualifier package
// Shared types, register codes and reset values for the motion qualifier.
// ----------------------------------------------------------------------------
package pmq_pkg;

   localparam int WINDOW_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [WINDOW_WIDTH-1:0] DEBOUNCE_RESET = 16'd200;
   localparam logic [WINDOW_WIDTH-1:0] HOLD_RESET = 16'd5000;
   localparam logic [WINDOW_WIDTH-1:0] WATCH_RESET = 16'd30000;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_HOLD     = 2'd2,
      PH_WATCH    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_MOTION = 2'd1,
      EV_ENDED  = 2'd2
   } event_type;

   // Register index, taken from the word address of the configuration port.
   typedef enum logic [1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_HOLD     = 2'd1,
      REG_WATCH    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [WINDOW_WIDTH-1:0] debounce_ms;
      logic [WINDOW_WIDTH-1:0] hold_ms;
      logic [WINDOW_WIDTH-1:0] watch_ms;
   } cfg_type;

endpackage

// ===== hw/rtl/pir_motion_qualifier.sv =====
// ----------------------------------------------------------------------------
// PIR motion qualifier
// Debounces a motion sensor and reports motion start and motion end words.
// ----------------------------------------------------------------------------
// The req channel carries one sensor sample per word: the sensor level and a
// strobe that marks one elapsed millisecond. For every accepted word exactly
// one rsp word comes out, with event code none, motion detected or motion
// ended. A word is accepted when valid is high and stall is low.
// An accepted word lands in an input register; once the output register is
// free, the state update runs on it and loads the event into the output
// register, which drives rsp_valid. One word per cycle is sustained while the
// receiver does not stall; the timer and phase update between the registers
// are combinational. While the receiver stalls, the waiting result holds and
// one more word is taken into the input register before req_stall goes high.
// The csr port holds the debounce, hold and watch lengths in milliseconds at
// byte addresses 0, 4 and 8; new values apply when a window is next loaded.
// Reset returns the registers to 200, 5000 and 30000, empties both stages,
// sets the phase to idle with edge detection armed and the last level low.
// ----------------------------------------------------------------------------
module pir_motion_qualifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_sensor_level,
   input  logic                                req_ms_tick,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_event_code,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pmq_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pmq_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pmq_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import pmq_pkg::*;

   cfg_type   cfg;
   event_type event_code;
   logic      advance;
   logic      req_accept;

   logic      in_valid_ff;
   logic      in_valid_in;
   logic      in_level_ff;
   logic      in_tick_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   event_type rsp_event_ff;

   // A sample moves on when the output register is empty or is being emptied.
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_level_ff <= req_sensor_level;
         in_tick_ff  <= req_ms_tick;
      end
      if (advance) begin
         rsp_event_ff <= event_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_event_ff;

   pmq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pmq_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .level      (in_level_ff),
      .tick       (in_tick_ff),
      .cfg        (cfg),
      .event_code (event_code)
   );

endmodule

// ===== hw/rtl/pmq_csr.sv =====
// ----------------------------------------------------------------------------
// PIR motion qualifier register block
// APB-style register file holding the three window lengths.
// ----------------------------------------------------------------------------
module pmq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pmq_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pmq_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pmq_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output pmq_pkg::cfg_type                    cfg
);
   import pmq_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_DEBOUNCE: cfg_in.debounce_ms = csr_pwdata[WINDOW_WIDTH-1:0];
            REG_HOLD:     cfg_in.hold_ms = csr_pwdata[WINDOW_WIDTH-1:0];
            REG_WATCH:    cfg_in.watch_ms = csr_pwdata[WINDOW_WIDTH-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_DEBOUNCE: csr_prdata = {{(CSR_DATA_WIDTH-WINDOW_WIDTH){1'b0}}, cfg_ff.debounce_ms};
         REG_HOLD:     csr_prdata = {{(CSR_DATA_WIDTH-WINDOW_WIDTH){1'b0}}, cfg_ff.hold_ms};
         REG_WATCH:    csr_prdata = {{(CSR_DATA_WIDTH-WINDOW_WIDTH){1'b0}}, cfg_ff.watch_ms};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= DEBOUNCE_RESET;
         cfg_ff.hold_ms     <= HOLD_RESET;
         cfg_ff.watch_ms    <= WATCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/pmq_core.sv =====
// ----------------------------------------------------------------------------
// PIR motion qualifier core
// Phase state, window timer and edge detector, updated once per sample.
// ----------------------------------------------------------------------------
module pmq_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               level,
   input  logic               tick,
   input  pmq_pkg::cfg_type   cfg,
   output pmq_pkg::event_type event_code
);
   import pmq_pkg::*;

   phase_type               phase_ff;
   phase_type               phase_in;
   logic [WINDOW_WIDTH-1:0] count_ff;
   logic [WINDOW_WIDTH-1:0] count_in;
   logic                    running_ff;
   logic                    running_in;
   logic                    armed_ff;
   logic                    armed_in;
   logic                    last_ff;
   logic                    last_in;
   logic                    expired;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      running_in = running_ff;
      armed_in   = armed_ff;
      last_in    = level;
      event_code = EV_NONE;
      expired    = 1'b0;

      // A window loaded with zero expires on the next sample, tick or not.
      if (running_ff) begin
         if (count_ff == '0) begin
            expired = 1'b1;
         end else if (tick) begin
            count_in = count_ff - 1'b1;
            expired  = (count_ff == {{(WINDOW_WIDTH-1){1'b0}}, 1'b1});
         end
      end

      if (expired) begin
         running_in = 1'b0;
         case (phase_ff)
            PH_DEBOUNCE: begin
               if (level) begin
                  event_code = EV_MOTION;
                  phase_in   = PH_HOLD;
                  count_in   = cfg.hold_ms;
                  running_in = 1'b1;
               end else begin
                  armed_in = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            PH_HOLD: begin
               armed_in   = 1'b1;
               phase_in   = PH_WATCH;
               count_in   = cfg.watch_ms;
               running_in = 1'b1;
            end
            PH_WATCH: begin
               event_code = EV_ENDED;
               phase_in   = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // Edge detection sees the arm flag as the timer left it in this sample.
      if (armed_in && level && !last_ff) begin
         armed_in   = 1'b0;
         phase_in   = PH_DEBOUNCE;
         count_in   = cfg.debounce_ms;
         running_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         running_ff <= 1'b0;
         armed_ff   <= 1'b1;
         last_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         running_ff <= running_in;
         armed_ff   <= armed_in;
         last_ff    <= last_in;
      end
   end

   a_running_matches_phase: assert property (@(posedge clock) disable iff (reset)
      running_ff == (phase_ff != PH_IDLE))
      else $error("window timer state disagrees with phase");

   a_disarmed_in_window: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (phase_ff == PH_DEBOUNCE || phase_ff == PH_HOLD))
      else $error("edge detection disarmed outside debounce or hold");

   a_motion_from_debounce: assert property (@(posedge clock) disable iff (reset)
      (advance && event_code == EV_MOTION) |-> (phase_ff == PH_DEBOUNCE && level)
         ##1 (phase_ff == PH_HOLD || phase_ff == PH_DEBOUNCE))
      else $error("motion reported outside a confirmed debounce");

   a_ended_from_watch: assert property (@(posedge clock) disable iff (reset)
      (advance && event_code == EV_ENDED) |-> phase_ff == PH_WATCH
         ##1 (phase_ff == PH_IDLE || phase_ff == PH_DEBOUNCE))
      else $error("motion end reported outside the watch window");

endmodule
